/* rtl/core/spa_pkg.sv */
package spa_pkg;

    // Pool geometry
    localparam int SLOTS      = 32;
    localparam int SLOT_W     = 5;
    localparam int DATA_WIDTH = 32;
    localparam int COUNT_W    = 6;

    // Request codes
    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_FIRST  = 3'd2;
    localparam logic [2:0] REQ_NEXT   = 3'd3;
    localparam logic [2:0] REQ_GET    = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NONE      = 2'd2;
    localparam logic [1:0] ST_INVARIANT = 2'd3;

    typedef struct packed {
        logic [2:0]            req_type;
        logic [SLOT_W-1:0]     slot_index;
        logic [DATA_WIDTH-1:0] item_data;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [SLOT_W-1:0]     result_slot;
        logic [DATA_WIDTH-1:0] read_data;
        logic [COUNT_W-1:0]    occupied_count;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_cmd_t;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

/* rtl/core/spa_ctrl.sv */
module spa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output spa_pkg::ctrl_cmd_t cmd
);

    spa_pkg::state_t state_reg;
    spa_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    // Output register can take a result this cycle
    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spa_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = spa_pkg::S_EXEC;
                end
            end
            spa_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = spa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spa_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            spa_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            spa_pkg::S_EXEC:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spa_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A captured transaction is always followed by the execute cycle
    a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == spa_pkg::S_EXEC)
        else $error("capture not followed by execute");

    // A commit never overwrites a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten");

    // Every commit raises the result valid flag
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit without valid result");

endmodule

/* rtl/core/spa_datapath.sv */
module spa_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  spa_pkg::ctrl_cmd_t cmd,
    input  spa_pkg::req_t      req,
    output spa_pkg::rsp_t      rsp
);

    localparam int SLOTS   = spa_pkg::SLOTS;
    localparam int SLOT_W  = spa_pkg::SLOT_W;
    localparam int COUNT_W = spa_pkg::COUNT_W;
    localparam int DW      = spa_pkg::DATA_WIDTH;

    // Captured request and registered store read
    spa_pkg::req_t       req_reg;
    logic [DW-1:0]       rd_data_reg;
    logic [DW-1:0]       slot_store [SLOTS];

    // Free list, pointers and occupancy
    logic [SLOT_W-1:0]   free_fifo_reg [SLOTS];
    logic [SLOT_W-1:0]   head_reg;
    logic [SLOT_W-1:0]   head_next;
    logic [SLOT_W-1:0]   tail_reg;
    logic [SLOT_W-1:0]   tail_next;
    logic [COUNT_W-1:0]  free_count_reg;
    logic [COUNT_W-1:0]  free_count_next;
    logic [SLOTS-1:0]    occ_reg;
    logic [SLOTS-1:0]    occ_next;
    spa_pkg::rsp_t       rsp_reg;
    spa_pkg::rsp_t       rsp_next;

    // Execute-stage signals
    logic [SLOT_W-1:0]   pop_slot;
    logic                push_en;
    logic                store_en;
    logic [SLOTS-1:0]    search_mask;
    logic [SLOTS-1:0]    cand;
    logic [SLOTS-1:0]    lowest;
    logic [SLOT_W-1:0]   found_slot;

    assign pop_slot = free_fifo_reg[head_reg];

    // Lowest occupied slot within the search window
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            if (req_reg.req_type == spa_pkg::REQ_NEXT)
            begin
                search_mask[i] = (SLOT_W'(i) > req_reg.slot_index);
            end
            else
            begin
                search_mask[i] = 1'b1;
            end
        end
        cand       = occ_reg & search_mask;
        lowest     = cand & (~cand + SLOTS'(1));
        found_slot = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (lowest[i])
            begin
                found_slot = found_slot | SLOT_W'(i);
            end
        end
    end

    // Operation decode
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_count_next = free_count_reg;
        occ_next        = occ_reg;
        push_en         = 1'b0;
        store_en        = 1'b0;
        rsp_next        = '0;
        rsp_next.status = spa_pkg::ST_OK;
        case (req_reg.req_type)
            spa_pkg::REQ_ADD:
            begin
                if (free_count_reg == '0)
                begin
                    rsp_next.status = spa_pkg::ST_FULL;
                end
                else if (occ_reg[pop_slot])
                begin
                    rsp_next.status = spa_pkg::ST_INVARIANT;
                end
                else
                begin
                    head_next = (head_reg == SLOT_W'(SLOTS - 1)) ? '0 : head_reg + 1'b1;
                    free_count_next = free_count_reg - 1'b1;
                    occ_next[pop_slot] = 1'b1;
                    store_en = 1'b1;
                end
            end
            spa_pkg::REQ_REMOVE:
            begin
                if (!occ_reg[req_reg.slot_index] || free_count_reg >= COUNT_W'(SLOTS))
                begin
                    rsp_next.status = spa_pkg::ST_INVARIANT;
                end
                else
                begin
                    push_en   = 1'b1;
                    tail_next = (tail_reg == SLOT_W'(SLOTS - 1)) ? '0 : tail_reg + 1'b1;
                    free_count_next = free_count_reg + 1'b1;
                    occ_next[req_reg.slot_index] = 1'b0;
                end
            end
            spa_pkg::REQ_FIRST, spa_pkg::REQ_NEXT:
            begin
                if (cand == '0)
                begin
                    rsp_next.status = spa_pkg::ST_NONE;
                end
                else
                begin
                    rsp_next.result_slot = found_slot;
                end
            end
            spa_pkg::REQ_GET:
            begin
                rsp_next.read_data = rd_data_reg;
            end
            default:
            begin
                rsp_next.status = spa_pkg::ST_OK;
            end
        endcase
        rsp_next.occupied_count = COUNT_W'(SLOTS) - free_count_next;
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
    end

    // Slot data store: read on capture, write on committed add
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_data_reg <= slot_store[req.slot_index];
        end
        if (cmd.commit && store_en)
        begin
            slot_store[pop_slot] <= req_reg.item_data;
        end
    end

    // Free list entries start as 0..SLOTS-1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                free_fifo_reg[i] <= SLOT_W'(i);
            end
        end
        else if (cmd.commit && push_en)
        begin
            free_fifo_reg[tail_reg] <= req_reg.slot_index;
        end
    end

    // Pointers, count and bitmap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            free_count_reg <= COUNT_W'(SLOTS);
            occ_reg        <= '0;
        end
        else if (cmd.commit)
        begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            free_count_reg <= free_count_next;
            occ_reg        <= occ_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

    // Free count never exceeds the pool size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= COUNT_W'(SLOTS))
        else $error("free count above pool size");

    // Occupied bits and free count always account for every slot
    a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_reg) + int'(free_count_reg) == SLOTS)
        else $error("bitmap and free count disagree");

    // A successful add occupies exactly one more slot
    a_add_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && store_en) |=> $countones(occ_reg) == $past($countones(occ_reg)) + 1)
        else $error("add did not mark one slot");

endmodule

/* rtl/core/slot_pool_allocator_core.sv */
// Slot pool allocator: 32 data slots managed by a free-slot FIFO and an
// occupancy bitmap. Requests (add, remove, first, next, get) arrive on the
// in_* channel and exactly one result per request leaves on the out_* channel;
// both are valid/ready transactions carrying packed structs.
//
// Timing: an accepted request is captured together with a registered read of
// the slot data store, then executed in the EXEC state, which updates the
// FIFO, bitmap and count and registers the result into the output register,
// from which it is valid on out_data. The block handles one request at a
// time: in_ready is low until the execute step of the last one has committed.
//
// Stalls: the result sits in an output register until taken. While it waits,
// the next request is still accepted; its execute step holds (in_ready low)
// until the output register is drained.
//
// Reset (rst_n, asynchronous, active low): the free FIFO holds 0..31 in order,
// the bitmap is clear, all slots are free. Slot data is not cleared; a get of
// a slot never written returns an unspecified value.
module slot_pool_allocator_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  spa_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output spa_pkg::rsp_t out_data
);

    spa_pkg::ctrl_cmd_t cmd;

    spa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    spa_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (in_data),
        .rsp   (out_data)
    );

endmodule
